### design/dictionary_word_search_macros.svh
// assertion macros for the dictionary word search block
`ifndef DICTIONARY_WORD_SEARCH_MACROS_SVH
`define DICTIONARY_WORD_SEARCH_MACROS_SVH

// condition implies consequence in the same cycle
`define DWS_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed in same cycle check");

// condition implies consequence in the next cycle
`define DWS_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed in next cycle check");

`endif

### design/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg
// shared constants and types of the dictionary word search block
// ----------------------------------------------------------------------------
package dws_pkg;

	localparam int MAX_WORDS = 4096;
	localparam int MAX_CHARS = 24;
	localparam int LETTERS   = 26;

	localparam int ADDR_W  = $clog2(MAX_WORDS);
	localparam int CNT_W   = $clog2(MAX_WORDS + 1);
	localparam int IDX_W   = $clog2(MAX_CHARS);
	localparam int POS_W   = $clog2(MAX_CHARS + 1);
	localparam int LET_W   = $clog2(LETTERS);
	localparam int PROBE_W = 13;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'(CHAR_A + LETTERS - 1);

	localparam logic [1:0] METHOD_SEQ    = 2'd0;
	localparam logic [1:0] METHOD_BIN    = 2'd1;
	localparam logic [1:0] METHOD_LETTER = 2'd2;

	// byte 0 is the most significant, so a plain compare is bytewise order
	typedef logic [0:MAX_CHARS-1][7:0] row_t;

	typedef struct packed {
		row_t              key;
		logic              seq;
		logic              empty;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
	} req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		row_t              data;
	} wr_t;

endpackage

### design/dictionary_word_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dictionary_word_search
// sorted word store with sequential and binary key search
// ----------------------------------------------------------------------------
// usage
//   in channel: one character per request (mode, key_char, last_char);
//   mode 0 loads a dictionary word, mode 1 builds a query key; words must
//   arrive in ascending order.
//   a query's last character queues a search; out channel returns found
//   and probe_count for each query, in order.
//   cfg channel: search_method, always ready, write only while idle.
//   probes: binary search at most 13 probes, sequential up to word count
//   probes.
//   throughput: set by the single read port of the word store, one probe
//   per read and compare pair; two searches can wait in the queue.
//   reset: word count, letter counts and position clear, method becomes 1;
//   the word store itself is not cleared.
//   receiver stall: the result holds in the output register, the engine
//   then waits and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
`include "dictionary_word_search_macros.svh"

module dictionary_word_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  key_char,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [12:0] probe_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  search_method
);

	logic [1:0]    method_r_q;
	logic          in_fire;
	logic          push, pop, q_full, q_valid;
	dws_pkg::req_t req, q_req;
	dws_pkg::wr_t  wr;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_r_q <= dws_pkg::METHOD_BIN;
		end else if (cfg_valid && cfg_ready) begin
			method_r_q <= search_method;
		end
	end

	dws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.mode      (mode),
		.key_char  (key_char),
		.last_char (last_char),
		.method    (method_r_q),
		.push      (push),
		.req       (req),
		.wr        (wr)
	);

	dws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (req),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_req)
	);

	dws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.pop         (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.found       (found),
		.probe_count (probe_count)
	);

	`DWS_ASSERT_NOW(a_probe_bound, out_valid, probe_count <= 13'(dws_pkg::MAX_WORDS))
	`DWS_ASSERT_NOW(a_found_probed, out_valid && found, probe_count != 13'd0)
	`DWS_ASSERT_NEXT(a_query_queued, in_valid && in_ready && mode && last_char, q_valid)

endmodule

### design/dws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_front
// assembles words and keys, keeps the letter table and issues search requests
// ----------------------------------------------------------------------------
module dws_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               mode,
	input  logic [7:0]         key_char,
	input  logic               last_char,
	input  logic [1:0]         method,
	output logic               push,
	output dws_pkg::req_t      req,
	output dws_pkg::wr_t       wr
);

	logic [dws_pkg::POS_W-1:0]  pos_q;
	logic [dws_pkg::CNT_W-1:0]  wcount_q;
	dws_pkg::row_t              wbuf_q;
	dws_pkg::row_t              qbuf_q;
	logic [dws_pkg::CNT_W-1:0]  lcount_q [dws_pkg::LETTERS];
	logic [dws_pkg::ADDR_W-1:0] lfirst_q [dws_pkg::LETTERS];

	logic                       inb;
	logic                       room;
	logic [dws_pkg::POS_W-1:0]  posn;
	dws_pkg::row_t              wnext, qnext, wpad, qpad;
	logic                       wlet_ok, qlet_ok;
	logic [dws_pkg::LET_W-1:0]  wlet, qlet;
	logic                       commit;

	always_comb begin
		inb   = pos_q < dws_pkg::POS_W'(dws_pkg::MAX_CHARS);
		room  = wcount_q < dws_pkg::CNT_W'(dws_pkg::MAX_WORDS);
		wnext = wbuf_q;
		qnext = qbuf_q;
		if (inb && !mode && room) begin
			wnext[pos_q[dws_pkg::IDX_W-1:0]] = key_char;
		end
		if (inb && mode) begin
			qnext[pos_q[dws_pkg::IDX_W-1:0]] = key_char;
		end
		posn = inb ? dws_pkg::POS_W'(pos_q + 1'b1) : pos_q;
		for (int k = 0; k < dws_pkg::MAX_CHARS; k++) begin
			wpad[k] = (dws_pkg::POS_W'(k) < posn) ? wnext[k] : 8'h00;
			qpad[k] = (dws_pkg::POS_W'(k) < posn) ? qnext[k] : 8'h00;
		end
		wlet_ok = (wpad[0] >= dws_pkg::CHAR_A) && (wpad[0] <= dws_pkg::CHAR_Z);
		qlet_ok = (qpad[0] >= dws_pkg::CHAR_A) && (qpad[0] <= dws_pkg::CHAR_Z);
		wlet    = dws_pkg::LET_W'(wpad[0] - dws_pkg::CHAR_A);
		qlet    = dws_pkg::LET_W'(qpad[0] - dws_pkg::CHAR_A);
	end

	assign commit  = in_fire && !mode && last_char && room;
	assign push    = in_fire && mode && last_char;
	assign wr.en   = commit;
	assign wr.addr = wcount_q[dws_pkg::ADDR_W-1:0];
	assign wr.data = wpad;

	always_comb begin
		req.key   = qpad;
		req.seq   = 1'b0;
		req.empty = (wcount_q == '0);
		req.lo    = '0;
		req.hi    = dws_pkg::ADDR_W'(wcount_q - 1'b1);
		case (method)
			dws_pkg::METHOD_SEQ: begin
				req.seq = 1'b1;
			end
			dws_pkg::METHOD_LETTER: begin
				if (qlet_ok && lcount_q[qlet] != '0) begin
					req.empty = 1'b0;
					req.lo    = lfirst_q[qlet];
					req.hi    = dws_pkg::ADDR_W'(dws_pkg::CNT_W'(lfirst_q[qlet])
						+ lcount_q[qlet] - 1'b1);
				end else begin
					req.empty = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			wcount_q <= '0;
			for (int l = 0; l < dws_pkg::LETTERS; l++) begin
				lcount_q[l] <= '0;
			end
		end else if (in_fire) begin
			pos_q <= last_char ? '0 : posn;
			if (commit) begin
				wcount_q <= dws_pkg::CNT_W'(wcount_q + 1'b1);
				if (wlet_ok) begin
					lcount_q[wlet] <= dws_pkg::CNT_W'(lcount_q[wlet] + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wbuf_q <= wnext;
			qbuf_q <= qnext;
			if (commit && wlet_ok && lcount_q[wlet] == '0) begin
				lfirst_q[wlet] <= wcount_q[dws_pkg::ADDR_W-1:0];
			end
		end
	end

endmodule

### design/dws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module dws_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dws_pkg::req_t push_req,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output dws_pkg::req_t head
);

	dws_pkg::req_t slot_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_req;
		end
	end

endmodule

### design/dws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_back
// word store and search engine, one probe per read and compare pair
// ----------------------------------------------------------------------------
module dws_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dws_pkg::wr_t                wr,
	input  logic                        q_valid,
	input  dws_pkg::req_t               q_req,
	output logic                        pop,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        found,
	output logic [dws_pkg::PROBE_W-1:0] probe_count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

	state_t                      state_q;
	dws_pkg::row_t               mem [dws_pkg::MAX_WORDS];
	dws_pkg::row_t               rd_q;
	dws_pkg::row_t               key_q;
	logic                        seq_q;
	logic [dws_pkg::ADDR_W-1:0]  lo_q, hi_q, idx_q;
	logic                        hit_q;
	logic [dws_pkg::PROBE_W-1:0] probes_q;
	logic [dws_pkg::ADDR_W-1:0]  rd_addr;
	logic [dws_pkg::ADDR_W:0]    mid_sum;

	assign pop     = q_valid && (state_q == S_IDLE);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign rd_addr = seq_q ? lo_q : mid_sum[dws_pkg::ADDR_W:1];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (state_q == S_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			found     <= 1'b0;
			probe_count <= '0;
			hit_q     <= 1'b0;
			probes_q  <= '0;
			key_q     <= '0;
			seq_q     <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			idx_q     <= '0;
		end else begin
			if (out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						key_q    <= q_req.key;
						seq_q    <= q_req.seq;
						lo_q     <= q_req.lo;
						hi_q     <= q_req.hi;
						hit_q    <= 1'b0;
						probes_q <= '0;
						state_q  <= q_req.empty ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					idx_q   <= rd_addr;
					state_q <= S_CMP;
				end
				S_CMP: begin
					probes_q <= probes_q + 1'b1;
					if (key_q == rd_q) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (key_q < rd_q) begin
						if (seq_q || idx_q == lo_q) begin
							state_q <= S_DONE;
						end else begin
							hi_q    <= idx_q - 1'b1;
							state_q <= S_READ;
						end
					end else if (idx_q == hi_q) begin
						state_q <= S_DONE;
					end else begin
						lo_q    <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						found       <= hit_q;
						probe_count <= probes_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the dictionary word search block against an in-bench search model
//
// a sorted dictionary is loaded in slices, each under a method set while
// the block is idle; a mix of present, altered and noise keys is queried
// after each slice. the run ends with a few queries, no random gaps. each
// found / probe_count result is compared with the model's answer in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 2000000;

	typedef struct {
		logic       m;
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	typedef struct {
		logic        hit;
		logic [12:0] probes;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [7:0]  key_char = 8'h00;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [12:0] probe_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  search_method = dws_pkg::METHOD_BIN;

	dictionary_word_search DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .key_char(key_char), .last_char(last_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .probe_count(probe_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.search_method(search_method)
	);

	// search model state
	dws_pkg::row_t store_rows [dws_pkg::MAX_WORDS];
	dws_pkg::row_t key_row;
	int            stored_words = 0;
	int            char_pos = 0;
	int            letter_start [dws_pkg::LETTERS];
	int            letter_words [dws_pkg::LETTERS];
	logic [1:0]    active_method = dws_pkg::METHOD_BIN;

	char_req_t     char_queue [$];
	answer_t       pending_answers [$];
	dws_pkg::row_t lexicon [$];
	int            mismatches = 0;
	bit            in_fire = 1'b0;
	bit            calm = 1'b0;
	int            in_gap = 0;
	int            out_gap = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int compare_key(int slot);
		if (key_row < store_rows[slot])
			return -1;
		if (key_row > store_rows[slot])
			return 1;
		return 0;
	endfunction

	function automatic void binary_probe(int lo, int hi, ref answer_t a);
		int mid;
		int c;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			c = compare_key(mid);
			a.probes++;
			if (c < 0)
				hi = mid - 1;
			else if (c > 0)
				lo = mid + 1;
			else begin
				a.hit = 1'b1;
				return;
			end
		end
	endfunction

	function automatic void take_char(logic m, logic [7:0] ch, logic last);
		bit room;
		int p;
		int letter;
		int c;
		answer_t a;
		room = stored_words < dws_pkg::MAX_WORDS;
		p = char_pos;
		if (p < dws_pkg::MAX_CHARS) begin
			if (m)
				key_row[p] = ch;
			else if (room)
				store_rows[stored_words][p] = ch;
			p++;
		end
		if (!last) begin
			char_pos = p;
			return;
		end
		char_pos = 0;
		if (!m) begin
			if (!room)
				return;
			for (; p < dws_pkg::MAX_CHARS; p++)
				store_rows[stored_words][p] = 8'h00;
			letter = int'(store_rows[stored_words][0]) - int'(dws_pkg::CHAR_A);
			if (letter >= 0 && letter < dws_pkg::LETTERS) begin
				if (letter_words[letter] == 0)
					letter_start[letter] = stored_words;
				letter_words[letter]++;
			end
			stored_words++;
			return;
		end
		for (; p < dws_pkg::MAX_CHARS; p++)
			key_row[p] = 8'h00;
		a.hit = 1'b0;
		a.probes = '0;
		if (active_method == dws_pkg::METHOD_SEQ) begin
			for (int i = 0; i < stored_words; i++) begin
				c = compare_key(i);
				a.probes++;
				if (c == 0)
					a.hit = 1'b1;
				if (c <= 0)
					break;
			end
		end else if (active_method == dws_pkg::METHOD_LETTER) begin
			letter = int'(key_row[0]) - int'(dws_pkg::CHAR_A);
			if (letter >= 0 && letter < dws_pkg::LETTERS && letter_words[letter] != 0)
				binary_probe(letter_start[letter],
					letter_start[letter] + letter_words[letter] - 1, a);
		end else begin
			binary_probe(0, stored_words - 1, a);
		end
		pending_answers.push_back(a);
	endfunction

	always @(posedge clk) begin
		answer_t e;
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			take_char(mode, key_char, last_char);
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				if (mismatches < 10)
					$display("result with nothing pending: found %0d probes %0d",
						found, probe_count);
				mismatches++;
			end else begin
				e = pending_answers.pop_front();
				if (found !== e.hit || probe_count !== e.probes) begin
					if (mismatches < 10)
						$display("mismatch: expected found %0d probes %0d, got %0d %0d",
							e.hit, e.probes, found, probe_count);
					mismatches++;
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		char_req_t r;
		if (!arst_n)
			in_valid <= 1'b0;
		else if (in_valid && !in_fire)
			;
		else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (char_queue.size() > 0) begin
			if (!calm && $urandom_range(0, 11) == 0) begin
				in_valid <= 1'b0;
				in_gap <= $urandom_range(0, 4);
			end else begin
				r = char_queue.pop_front();
				in_valid <= 1'b1;
				mode <= r.m;
				key_char <= r.ch;
				last_char <= r.last;
			end
		end else
			in_valid <= 1'b0;
	end

	// result stall driver
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			out_gap <= $urandom_range(0, 4);
		end else
			out_ready <= 1'b1;
	end

	task automatic push_text(logic m, dws_pkg::row_t text, int len);
		char_req_t r;
		for (int i = 0; i < len; i++) begin
			r.m = m;
			r.ch = (i < dws_pkg::MAX_CHARS) ? text[i] : 8'($urandom_range(1, 255));
			r.last = (i == len - 1);
			char_queue.push_back(r);
		end
	endtask

	function automatic int text_len(dws_pkg::row_t text);
		int n;
		n = 0;
		for (int i = 0; i < dws_pkg::MAX_CHARS; i++)
			if (text[i] != 8'h00)
				n = i + 1;
		if (n == dws_pkg::MAX_CHARS)
			n += $urandom_range(0, 4);
		return n;
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (char_queue.size() != 0 || in_valid || pending_answers.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_method(logic [1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		search_method <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		active_method = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic query_mix(int loaded, int count);
		dws_pkg::row_t t;
		int len;
		int pick;
		for (int q = 0; q < count; q++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60 && loaded > 0) begin
				t = lexicon[$urandom_range(0, loaded - 1)];
				push_text(1'b1, t, text_len(t));
			end else if (pick < 82 && loaded > 0) begin
				t = lexicon[$urandom_range(0, loaded - 1)];
				len = text_len(t);
				case ($urandom_range(0, 2))
					0: t[$urandom_range(0, (len > dws_pkg::MAX_CHARS ?
						dws_pkg::MAX_CHARS : len) - 1)] = 8'($urandom_range(1, 255));
					1: len++;
					default: if (len > 1) len--;
				endcase
				push_text(1'b1, t, len);
			end else begin
				len = $urandom_range(1, 30);
				for (int i = 0; i < dws_pkg::MAX_CHARS; i++)
					t[i] = ($urandom_range(0, 49) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
				if ($urandom_range(0, 1))
					t[0] = 8'($urandom_range(int'(dws_pkg::CHAR_A), int'(dws_pkg::CHAR_Z)));
				push_text(1'b1, t, len);
			end
		end
	endtask

	initial begin
		dws_pkg::row_t t;
		int len;
		int loaded;
		logic [1:0] plan [8];

		plan = '{dws_pkg::METHOD_SEQ, dws_pkg::METHOD_LETTER, dws_pkg::METHOD_BIN, 2'd3,
			dws_pkg::METHOD_LETTER, dws_pkg::METHOD_SEQ, dws_pkg::METHOD_BIN,
			dws_pkg::METHOD_LETTER};
		for (int i = 0; i < dws_pkg::LETTERS; i++) begin
			letter_start[i] = 0;
			letter_words[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, zero byte, top byte, mixed modes, non-letter key
		t = '0;
		t[0] = "a"; t[1] = "b";
		push_text(1'b1, t, 2);
		t = '0;
		t[0] = 8'h01; t[1] = 8'h00; t[2] = 8'hff;
		push_text(1'b0, t, 3);
		push_text(1'b1, t, 3);
		char_queue.push_back('{1'b0, "E", 1'b0});
		char_queue.push_back('{1'b0, "F", 1'b0});
		char_queue.push_back('{1'b1, "z", 1'b1});
		char_queue.push_back('{1'b0, "G", 1'b1});
		t = '0;
		t[0] = "G";
		push_text(1'b1, t, 1);
		t = '0;
		t[0] = "A";
		push_text(1'b1, t, 1);
		t = '0;
		push_text(1'b1, t, 1);
		wait_idle();

		// sorted dictionary, loaded in slices
		for (int w = 0; w < 120; w++) begin
			len = ($urandom_range(0, 19) == 0) ? dws_pkg::MAX_CHARS : $urandom_range(1, 8);
			t = '0;
			for (int i = 0; i < len; i++)
				t[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(int'(dws_pkg::CHAR_A), int'(dws_pkg::CHAR_Z)));
			if ($urandom_range(0, 9) == 0)
				t[0] = 8'($urandom_range(int'(dws_pkg::CHAR_Z) + 1, 255));
			lexicon.push_back(t);
		end
		lexicon.sort();

		loaded = 0;
		for (int ph = 0; ph < 8; ph++) begin
			write_method(plan[ph]);
			for (int w = 0; w < 15; w++) begin
				push_text(1'b0, lexicon[loaded], text_len(lexicon[loaded]));
				loaded++;
			end
			query_mix(loaded, 5);
			wait_idle();
		end

		// final stretch without random gaps
		calm = 1'b1;
		query_mix(loaded, 6);
		wait_idle();
		write_method(dws_pkg::METHOD_SEQ);
		query_mix(loaded, 4);
		wait_idle();
		write_method(dws_pkg::METHOD_BIN);
		query_mix(loaded, 4);
		wait_idle();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && pending_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
